// ===== sv/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, skipped while reset is low
`define WSS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// property checked on every rising edge, reset included
`define WSS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/ws_ser_pkg.sv =====
// types and constants of the pulse-width led serializer
package ws_ser_pkg;

  localparam int unsigned ColorW    = 8;
  localparam int unsigned PixelW    = 3 * ColorW;
  localparam int unsigned BitCntW   = 5;
  localparam int unsigned TickW     = 18;
  localparam int unsigned PeriodW   = 16;
  localparam int unsigned ApbAddrW  = 4;
  localparam int unsigned ApbDataW  = 32;

  localparam logic [BitCntW-1:0] BitsPerPixel  = 5'd24;

  localparam logic [PeriodW-1:0] BitCyclesRst  = 16'd300;
  localparam logic [PeriodW-1:0] ZeroHighRst   = 16'd96;
  localparam logic [PeriodW-1:0] OneHighRst    = 16'd192;
  localparam logic [TickW-1:0]   LatchRst      = 18'd192000;

  typedef enum logic [1:0] {
    REG_BIT_CYCLES = 2'd0,
    REG_ZERO_HIGH  = 2'd1,
    REG_ONE_HIGH   = 2'd2,
    REG_LATCH      = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_SEND  = 2'd1,
    PH_LATCH = 2'd2
  } phase_e;

  typedef struct packed {
    logic [PeriodW-1:0] bit_cycles;
    logic [PeriodW-1:0] zero_high_cycles;
    logic [PeriodW-1:0] one_high_cycles;
    logic [TickW-1:0]   latch_cycles;
  } cfg_t;

  typedef struct packed {
    logic              last_pixel;
    logic [ColorW-1:0] blue;
    logic [ColorW-1:0] red;
    logic [ColorW-1:0] green;
    logic              pixel_valid;
  } item_t;

  typedef struct packed {
    logic starved;
    logic busy_res;
    logic pixel_taken;
    logic line_level;
  } res_t;

endpackage

// ===== sv/ws_ser_queue.sv =====
// two-entry request queue between the input channel and the engine
module ws_ser_queue import ws_ser_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  item_t push_item_i,
  output logic  pop_valid_o,
  input  logic  pop_i,
  output item_t pop_item_o
);

  item_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== sv/ws_ser_regs.sv =====
// timing registers behind the apb port
module ws_ser_regs import ws_ser_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_BIT_CYCLES: cfg_d.bit_cycles       = pwdata[PeriodW-1:0];
        REG_ZERO_HIGH:  cfg_d.zero_high_cycles = pwdata[PeriodW-1:0];
        REG_ONE_HIGH:   cfg_d.one_high_cycles  = pwdata[PeriodW-1:0];
        REG_LATCH:      cfg_d.latch_cycles     = pwdata[TickW-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_BIT_CYCLES: prdata = {{(ApbDataW-PeriodW){1'b0}}, cfg_q.bit_cycles};
      REG_ZERO_HIGH:  prdata = {{(ApbDataW-PeriodW){1'b0}}, cfg_q.zero_high_cycles};
      REG_ONE_HIGH:   prdata = {{(ApbDataW-PeriodW){1'b0}}, cfg_q.one_high_cycles};
      REG_LATCH:      prdata = {{(ApbDataW-TickW){1'b0}}, cfg_q.latch_cycles};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bit_cycles       <= BitCyclesRst;
      cfg_q.zero_high_cycles <= ZeroHighRst;
      cfg_q.one_high_cycles  <= OneHighRst;
      cfg_q.latch_cycles     <= LatchRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== sv/ws_ser_engine.sv =====
// per-tick serializer state machine and result register
module ws_ser_engine import ws_ser_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  item_valid_i,
  input  item_t item_i,
  output logic  item_pop_o,
  output logic  res_valid_o,
  input  logic  res_ready_i,
  output res_t  res_o
);

  phase_e             phase_q, phase_d, ph_cur;
  logic [PixelW-1:0]  held_pixel_q, held_pixel_d;
  logic               held_full_q, held_full_d;
  logic               held_last_q, held_last_d;
  logic [PixelW-1:0]  shift_q, shift_d, shift_cur;
  logic [BitCntW-1:0] bits_q, bits_d, bits_cur, bits_dec;
  logic               slast_q, slast_d, slast_cur;
  logic [TickW-1:0]   tick_q, tick_d, tick_cur, tick_inc;
  logic [PeriodW-1:0] high_time;
  logic               load, taken, step;
  res_t               res_d, res_q;
  logic               res_valid_q;

  // one step per queued tick, as long as the result register can take it
  assign step        = item_valid_i && (!res_valid_q || res_ready_i);
  assign item_pop_o  = step;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_comb begin
    unique case (phase_q)
      PH_SEND:  ph_cur = PH_SEND;
      PH_LATCH: ph_cur = PH_LATCH;
      default:  ph_cur = PH_IDLE;
    endcase

    // move the held pixel into the shifter when idle or between pixels
    load = held_full_q &&
           ((ph_cur == PH_IDLE) || ((ph_cur == PH_SEND) && (bits_q == '0)));

    shift_cur = load ? held_pixel_q : shift_q;
    bits_cur  = load ? BitsPerPixel : bits_q;
    slast_cur = load ? held_last_q : slast_q;
    tick_cur  = load ? '0 : tick_q;
    phase_d   = load ? PH_SEND : ph_cur;

    held_full_d = load ? 1'b0 : held_full_q;
    taken       = item_i.pixel_valid && !held_full_d;

    shift_d   = shift_cur;
    bits_d    = bits_cur;
    slast_d   = slast_cur;
    tick_d    = tick_cur;
    tick_inc  = tick_cur + 1'b1;
    bits_dec  = bits_cur - 1'b1;
    high_time = shift_cur[PixelW-1] ? cfg_i.one_high_cycles : cfg_i.zero_high_cycles;
    res_d     = '0;
    res_d.pixel_taken = taken;

    unique case (phase_d)
      PH_SEND: begin
        res_d.busy_res = 1'b1;
        if (bits_cur == '0) begin
          res_d.starved = 1'b1;
        end else begin
          res_d.line_level = (tick_cur < {{(TickW-PeriodW){1'b0}}, high_time});
          if (tick_inc >= {{(TickW-PeriodW){1'b0}}, cfg_i.bit_cycles}) begin
            tick_d  = '0;
            shift_d = {shift_cur[PixelW-2:0], 1'b0};
            bits_d  = bits_dec;
            if ((bits_dec == '0) && slast_cur) begin
              slast_d = 1'b0;
              phase_d = (cfg_i.latch_cycles == '0) ? PH_IDLE : PH_LATCH;
            end
          end else begin
            tick_d = tick_inc;
          end
        end
      end
      PH_LATCH: begin
        res_d.busy_res = 1'b1;
        if (tick_inc >= cfg_i.latch_cycles) begin
          tick_d  = '0;
          phase_d = PH_IDLE;
        end else begin
          tick_d = tick_inc;
        end
      end
      default: ;
    endcase

    held_pixel_d = held_pixel_q;
    held_last_d  = held_last_q;
    if (taken) begin
      held_pixel_d = {item_i.green, item_i.red, item_i.blue};
      held_last_d  = item_i.last_pixel;
      held_full_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      held_full_q <= 1'b0;
      held_last_q <= 1'b0;
      bits_q      <= '0;
      slast_q     <= 1'b0;
      tick_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (step) begin
        phase_q     <= phase_d;
        held_full_q <= held_full_d;
        held_last_q <= held_last_d;
        bits_q      <= bits_d;
        slast_q     <= slast_d;
        tick_q      <= tick_d;
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      held_pixel_q <= held_pixel_d;
      shift_q      <= shift_d;
      res_q        <= res_d;
    end
  end

endmodule

// ===== sv/ws2812_pixel_serializer_unit.sv =====
// top level of the pulse-width led serializer
// usage: every request on the s_axis channel is one tick of the led timing.
// tuser says whether a pixel is offered, tdata carries green, red and blue,
// tlast marks the pixel that ends a frame. for every request exactly one
// result leaves on m_axis: line level, pixel taken, busy and starved flags.
// the line level of consecutive results forms the led data waveform, with
// bit period, high times and latch time set over the apb port.
// a request passes the queue register, then the result register, before
// its result is valid.
// throughput: one request per cycle while the receiver is ready, as the
// engine takes one step per request; the two-entry queue lets input and
// output stall independently. reset: timing registers return to
// 300/96/192/192000 ticks, the holding register empties, the engine goes
// idle and the queue is empty. when the receiver stalls, the result
// register holds its value, the queue fills and s_axis_tready then drops
// until it drains. no led tick advances while requests are not flowing.
module ws2812_pixel_serializer_unit import ws_ser_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [23:0]         s_axis_tdata,   // green[7:0], red[15:8], blue[23:16]
  input  logic                s_axis_tuser,   // pixel_valid
  input  logic                s_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata,   // line_level, pixel_taken, busy_res, starved
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  cfg_t  cfg;
  item_t in_item, q_item;
  logic  q_valid, q_pop, res_valid;
  res_t  res;

  assign in_item.pixel_valid = s_axis_tuser;
  assign in_item.green       = s_axis_tdata[7:0];
  assign in_item.red         = s_axis_tdata[15:8];
  assign in_item.blue        = s_axis_tdata[23:16];
  assign in_item.last_pixel  = s_axis_tlast;

  ws_ser_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ws_ser_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (s_axis_tvalid),
    .push_ready_o (s_axis_tready),
    .push_item_i  (in_item),
    .pop_valid_o  (q_valid),
    .pop_i        (q_pop),
    .pop_item_o   (q_item)
  );

  ws_ser_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (q_valid),
    .item_i       (q_item),
    .item_pop_o   (q_pop),
    .res_valid_o  (res_valid),
    .res_ready_i  (m_axis_tready),
    .res_o        (res)
  );

  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = {4'b0000, res};

endmodule

// ===== sv/ws_ser_checker.sv =====
// port-level checks of the serializer, bound to the top level
`include "assert_macros.svh"

module ws_ser_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  // a stalled result keeps its value
  `WSS_ASSERT(a_res_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
  // the line is only driven high while a frame is in progress
  `WSS_ASSERT(a_line_busy, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[2], "line high while not busy")
  // starved means mid-frame with the line low
  `WSS_ASSERT(a_starve_low, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[2] && !m_axis_tdata[0], "starved with line high or not busy")
  // no result is offered in the cycle after a reset cycle
  `WSS_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |=> !m_axis_tvalid, "result valid after reset")

endmodule

bind ws2812_pixel_serializer_unit ws_ser_checker u_ws_ser_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== verif/tb_ws2812_pixel_serializer_unit.sv =====
// self-checking testbench of the led serializer: random led ticks against a tick-level predictor
`timescale 1ns / 1ps

module tb_ws2812_pixel_serializer_unit;
  import ws_ser_pkg::*;

  localparam int unsigned WatchLimit     = 3000;
  localparam int unsigned LongHoldCycles = 120;
  localparam int unsigned TargetTicks    = 1550;

  typedef struct {
    item_t it;
    bit    retry;  // offer again until the holding register takes it
  } tick_req_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [23:0]         s_axis_tdata  = '0;  // green[7:0], red[15:8], blue[23:16]
  logic                s_axis_tuser  = 1'b0;  // pixel_valid
  logic                s_axis_tlast  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;  // line_level, pixel_taken, busy_res, starved
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [ApbAddrW-1:0] paddr         = '0;
  logic [ApbDataW-1:0] pwdata        = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  // predictor state
  cfg_t              tim_cfg = '{BitCyclesRst, ZeroHighRst, OneHighRst, LatchRst};
  logic [PixelW-1:0] hold_pix;
  logic [PixelW-1:0] shift_pix;
  logic              hold_full;
  logic              hold_last;
  logic              shift_last;
  logic [BitCntW-1:0] bits_left;
  logic [TickW-1:0]  tick_cnt;
  phase_e            led_ph;

  tick_req_t   pend_q[$];
  res_t        line_exp_q[$];

  int unsigned snd_gap    = 0;
  int unsigned rcv_gap    = 0;
  int unsigned hold_cnt   = 0;
  int unsigned quiet_cnt  = 0;
  int unsigned idle_pct   = 10;
  bit          no_idle    = 1'b0;
  bit          hold_go    = 1'b0;
  int unsigned n_queued   = 0;
  int unsigned n_ticks    = 0;
  int unsigned n_results  = 0;
  int unsigned n_taken    = 0;
  int unsigned n_starved  = 0;
  int unsigned n_busy     = 0;
  int unsigned n_cfg      = 1;
  int unsigned n_err      = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  ws2812_pixel_serializer_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // one led tick: load stage, take stage, then timers
  task automatic led_tick(input item_t it, output res_t r);
    logic [PeriodW-1:0] high_len;
    r = '0;
    if ((led_ph == PH_IDLE || (led_ph == PH_SEND && bits_left == '0)) && hold_full) begin
      shift_pix  = hold_pix;
      bits_left  = BitsPerPixel;
      shift_last = hold_last;
      hold_full  = 1'b0;
      tick_cnt   = '0;
      led_ph     = PH_SEND;
    end
    r.pixel_taken = it.pixel_valid && !hold_full;
    if (led_ph == PH_SEND) begin
      r.busy_res = 1'b1;
      if (bits_left == '0) begin
        r.starved = 1'b1;
      end else begin
        high_len = shift_pix[PixelW-1] ? tim_cfg.one_high_cycles : tim_cfg.zero_high_cycles;
        r.line_level = (tick_cnt < high_len);
        tick_cnt = tick_cnt + 1'b1;
        if (tick_cnt >= tim_cfg.bit_cycles) begin
          tick_cnt  = '0;
          shift_pix = shift_pix << 1;
          bits_left = bits_left - 1'b1;
          if (bits_left == '0 && shift_last) begin
            shift_last = 1'b0;
            led_ph = (tim_cfg.latch_cycles == '0) ? PH_IDLE : PH_LATCH;
          end
        end
      end
    end else if (led_ph == PH_LATCH) begin
      r.busy_res = 1'b1;
      tick_cnt = tick_cnt + 1'b1;
      if (tick_cnt >= tim_cfg.latch_cycles) begin
        tick_cnt = '0;
        led_ph   = PH_IDLE;
      end
    end
    if (r.pixel_taken) begin
      hold_pix  = {it.green, it.red, it.blue};
      hold_last = it.last_pixel;
      hold_full = 1'b1;
    end
  endtask

  task automatic note_err(input string msg);
    n_err++;
    if (n_err <= 10) $display("ERROR: %s", msg);
  endtask

  // sender
  always @(posedge clk_i or negedge rst_ni) begin : drv
    item_t seen;
    res_t  nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      snd_gap       <= 0;
      hold_pix   = '0;
      shift_pix  = '0;
      hold_full  = 1'b0;
      hold_last  = 1'b0;
      shift_last = 1'b0;
      bits_left  = '0;
      tick_cnt   = '0;
      led_ph     = PH_IDLE;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        seen.pixel_valid = s_axis_tuser;
        seen.green       = s_axis_tdata[7:0];
        seen.red         = s_axis_tdata[15:8];
        seen.blue        = s_axis_tdata[23:16];
        seen.last_pixel  = s_axis_tlast;
        led_tick(seen, nxt);
        line_exp_q.push_back(nxt);
        n_ticks++;
        if (!(pend_q[0].retry && seen.pixel_valid && !nxt.pixel_taken))
          void'(pend_q.pop_front());
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // request stays on the bus until taken
      end else if (snd_gap != 0) begin
        snd_gap       <= snd_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (!no_idle && $urandom_range(99) < idle_pct) begin
        snd_gap       <= $urandom_range(18);
        s_axis_tvalid <= 1'b0;
      end else if (pend_q.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= pend_q[0].it.pixel_valid;
        s_axis_tdata  <= {pend_q[0].it.blue, pend_q[0].it.red, pend_q[0].it.green};
        s_axis_tlast  <= pend_q[0].it.last_pixel;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, started once on request of the stimulus
  always @(posedge clk_i or negedge rst_ni) begin : long_hold
    if (!rst_ni) begin
      hold_cnt <= 0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (hold_go) begin
      hold_cnt <= LongHoldCycles;
    end
  end

  // receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin : mon
    res_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rcv_gap       <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_results++;
        if (line_exp_q.size() == 0) begin
          note_err($sformatf("result %0d (tdata=%02h) with no request pending",
                             n_results, m_axis_tdata));
        end else begin
          want = line_exp_q.pop_front();
          n_taken   += want.pixel_taken;
          n_starved += want.starved;
          n_busy    += want.busy_res;
          if (m_axis_tdata !== {4'b0000, want})
            note_err($sformatf({"result %0d: exp line=%0b taken=%0b busy=%0b starved=%0b",
                                " pad=0, got line=%0b taken=%0b busy=%0b starved=%0b pad=%h"},
                               n_results, want.line_level, want.pixel_taken, want.busy_res,
                               want.starved, m_axis_tdata[0], m_axis_tdata[1],
                               m_axis_tdata[2], m_axis_tdata[3], m_axis_tdata[7:4]));
        end
      end
      if (hold_cnt != 0) begin
        m_axis_tready <= 1'b0;
      end else if (rcv_gap != 0) begin
        rcv_gap       <= rcv_gap - 1;
        m_axis_tready <= 1'b0;
      end else if (!no_idle && $urandom_range(99) < idle_pct) begin
        rcv_gap       <= $urandom_range(18);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : wdog
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cnt <= 0;
    end else if (quiet_cnt >= WatchLimit) begin
      $display("timeout: no transfer for %0d cycles, %0d results pending",
               WatchLimit, line_exp_q.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
  end

  task automatic push_tick(input bit vld, input logic [7:0] g, input logic [7:0] r,
                           input logic [7:0] b, input bit lst, input bit retry);
    tick_req_t q;
    q.it.pixel_valid = vld;
    q.it.green       = g;
    q.it.red         = r;
    q.it.blue        = b;
    q.it.last_pixel  = lst;
    q.retry          = retry;
    pend_q.push_back(q);
    n_queued++;
  endtask

  // idle ticks carry random data and last flags that the block must ignore
  task automatic push_idle(input int unsigned n);
    repeat (n) push_tick(1'b0, 8'($urandom_range(255)), 8'($urandom_range(255)),
                         8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0);
  endtask

  task automatic push_frame();
    int unsigned npix;
    bit          broken;
    npix   = $urandom_range(1, 4);
    broken = ($urandom_range(9) == 0);
    for (int unsigned p = 0; p < npix; p++) begin
      // now and then a gap long enough to starve the line mid-frame
      push_idle(($urandom_range(4) == 0) ? $urandom_range(20, 90) : $urandom_range(0, 2));
      if ($urandom_range(7) == 0)
        push_tick(1'b1, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0);
      push_tick(1'b1, 8'($urandom_range(255)), 8'($urandom_range(255)),
                8'($urandom_range(255)), (p == npix - 1) && !broken, 1'b1);
    end
    push_idle($urandom_range(0, 40));
  endtask

  task automatic drain_wait();
    while (pend_q.size() != 0 || line_exp_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input reg_idx_e idx, input logic [ApbDataW-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_BIT_CYCLES: tim_cfg.bit_cycles       = val[PeriodW-1:0];
      REG_ZERO_HIGH:  tim_cfg.zero_high_cycles = val[PeriodW-1:0];
      REG_ONE_HIGH:   tim_cfg.one_high_cycles  = val[PeriodW-1:0];
      REG_LATCH:      tim_cfg.latch_cycles     = val[TickW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_timing(input int unsigned bc, input int unsigned zh,
                            input int unsigned oh, input int unsigned lc);
    drain_wait();
    cfg_write(REG_BIT_CYCLES, bc);
    cfg_write(REG_ZERO_HIGH, zh);
    cfg_write(REG_ONE_HIGH, oh);
    cfg_write(REG_LATCH, lc);
    n_cfg++;
  endtask

  task automatic random_phase(input int unsigned n_req);
    int unsigned bc;
    int unsigned start;
    bc = ($urandom_range(5) == 0) ? $urandom_range(1) : $urandom_range(2, 4);
    set_timing(bc, $urandom_range(bc + 1), $urandom_range(bc + 1),
               ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 40));
    case ($urandom_range(3))
      0:       idle_pct <= 0;
      1:       idle_pct <= 4;
      2:       idle_pct <= 12;
      default: idle_pct <= 30;
    endcase
    start = n_queued;
    while (n_queued - start < n_req) push_frame();
  endtask

  initial begin : stim
    int unsigned start;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset timing: a white pixel starts, ignored data on an idle tick, a black last pixel held
    push_tick(1'b1, 8'hff, 8'hff, 8'hff, 1'b0, 1'b1);
    push_tick(1'b0, 8'hff, 8'hff, 8'hff, 1'b1, 1'b0);
    push_tick(1'b1, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0);

    // one-tick bits, zero bits always low, one bits always high, no latch
    set_timing(0, 0, 65535, 0);
    push_tick(1'b1, 8'ha5, 8'h00, 8'hff, 1'b0, 1'b1);
    push_idle(3);
    push_tick(1'b1, 8'h5a, 8'hff, 8'h00, 1'b1, 1'b1);
    push_idle(2);

    while (n_ticks < 400) random_phase(30);

    // receiver stalls for a long stretch while requests keep coming
    set_timing(2, 1, 2, 6);
    idle_pct <= 0;
    repeat (3) push_frame();
    @(posedge clk_i);
    hold_go <= 1'b1;
    @(posedge clk_i);
    hold_go <= 1'b0;

    while (n_ticks < TargetTicks - 650) random_phase(30);

    // let the last frame and its latch run out before the long timings
    push_idle(300);

    // widest bit period and high time, longest latch
    set_timing(65535, 65535, 1, 262143);
    push_tick(1'b1, 8'h00, 8'h0f, 8'hf0, 1'b0, 1'b1);
    push_idle(20);
    set_timing(2, 1, 65535, 262143);
    push_tick(1'b1, 8'hc3, 8'h3c, 8'h81, 1'b1, 1'b1);
    push_idle(80);

    // final stretch without idling
    no_idle <= 1'b1;
    set_timing(3, 1, 2, 10);
    start = n_queued;
    while (n_queued - start < 40) push_frame();
    drain_wait();

    $display("ran %0d led ticks over %0d timing settings", n_ticks, n_cfg);
    $display("predicted %0d pixels taken, %0d busy ticks, %0d starved ticks, %0d errors",
             n_taken, n_busy, n_starved, n_err);
    if (n_err == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
